@@ rtl/core/sldf_pkg.sv @@
// Shared types and constants for the sync/length frame deframer.
`timescale 1ns / 1ps
package sldf_pkg;

    localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND  = 8'h55;
    localparam logic [15:0] HEADER_BYTES = 16'd4;
    localparam logic [15:0] LIMIT_RESET  = 16'd256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Index of the last header word when a header command is expanded
    localparam logic [1:0] HDR_LAST_IDX = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT_AA  = 3'd0,
        PH_HUNT_55  = 3'd1,
        PH_LEN_HI   = 3'd2,
        PH_LEN_LO   = 3'd3,
        PH_PAYLOAD  = 3'd4
    } t_phase;

    // One command from the parser to the output side
    typedef struct packed {
        logic        is_header;   // expands into four header words
        logic [7:0]  data_byte;   // payload byte, or low length byte for a header
        logic [7:0]  len_hi;      // high length byte (header only)
        logic [15:0] offset;      // payload byte offset
        logic [15:0] length;      // frame length
        logic        last;        // final payload byte
    } t_cmd;

endpackage

@@ rtl/core/sldf_front.sv @@
// Front end: parses received bytes into header and payload commands.
`timescale 1ns / 1ps
module sldf_front
    import sldf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_byte,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_acc_len, n_acc_len;
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_limit;

    logic [15:0] w_len;
    logic        w_len_ok;
    logic        w_pay_last;

    assign w_len      = {r_len_hi, i_byte};
    assign w_len_ok   = (w_len < r_limit) && (w_len >= HEADER_BYTES);
    assign w_pay_last = ({1'b0, r_offset} + 17'd1) >= {1'b0, r_acc_len};

    // Hold the length limit; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // Advance the parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT_AA;
            r_len_hi  <= 8'd0;
            r_acc_len <= 16'd0;
            r_offset  <= 16'd0;
        end else if (i_byte_valid) begin
            r_phase   <= n_phase;
            r_len_hi  <= n_len_hi;
            r_acc_len <= n_acc_len;
            r_offset  <= n_offset;
        end
    end

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_len_hi  = r_len_hi;
        n_acc_len = r_acc_len;
        n_offset  = r_offset;
        case (r_phase)
            PH_HUNT_55: begin
                if (i_byte == SYNC_SECOND) begin
                    n_phase = PH_LEN_HI;
                end else if (i_byte != SYNC_FIRST) begin
                    n_phase = PH_HUNT_AA;
                end
            end
            PH_LEN_HI: begin
                n_len_hi = i_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (!w_len_ok) begin
                    n_phase = PH_HUNT_AA;
                end else begin
                    n_acc_len = w_len;
                    if (w_len == HEADER_BYTES) begin
                        n_phase = PH_HUNT_AA;
                    end else begin
                        n_offset = HEADER_BYTES;
                        n_phase  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (w_pay_last) begin
                    n_phase = PH_HUNT_AA;
                end else begin
                    n_offset = r_offset + 16'd1;
                end
            end
            default: begin
                n_phase = (i_byte == SYNC_FIRST) ? PH_HUNT_55 : PH_HUNT_AA;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        o_push          = 1'b0;
        o_cmd.is_header = 1'b0;
        o_cmd.data_byte = i_byte;
        o_cmd.len_hi    = r_len_hi;
        o_cmd.offset    = r_offset;
        o_cmd.length    = r_acc_len;
        o_cmd.last      = w_pay_last;
        case (r_phase)
            PH_LEN_LO: begin
                o_push          = i_byte_valid && w_len_ok;
                o_cmd.is_header = 1'b1;
                o_cmd.length    = w_len;
                o_cmd.last      = (w_len == HEADER_BYTES);
            end
            PH_PAYLOAD: begin
                o_push = i_byte_valid;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/sldf_queue.sv @@
// Short command queue between the parser and the output side.
`timescale 1ns / 1ps
module sldf_queue
    import sldf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/sldf_back.sv @@
// Back end: expands commands into output words and drives the master stream.
`timescale 1ns / 1ps
module sldf_back
    import sldf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic [15:0] o_byte_offset,
    output logic [15:0] o_frame_length,
    output logic        o_last_of_frame
);

    logic       r_busy, n_busy;
    t_cmd       r_cmd, n_cmd;
    logic [1:0] r_idx, n_idx;

    logic w_take;
    logic w_advance;

    assign w_take    = r_busy && i_ready;
    assign w_advance = !r_busy || w_take;

    // Step through header words, else pull the next command
    always_comb begin
        n_busy = r_busy;
        n_cmd  = r_cmd;
        n_idx  = r_idx;
        o_pop  = 1'b0;
        if (w_take && r_cmd.is_header && (r_idx != HDR_LAST_IDX)) begin
            n_idx = r_idx + 2'd1;
        end else if (w_advance) begin
            if (!i_empty) begin
                o_pop  = 1'b1;
                n_cmd  = i_cmd;
                n_idx  = 2'd0;
                n_busy = 1'b1;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // Select the word fields
    always_comb begin
        o_valid        = r_busy;
        o_frame_length = r_cmd.length;
        if (r_cmd.is_header) begin
            o_byte_offset   = {14'd0, r_idx};
            o_last_of_frame = r_cmd.last && (r_idx == HDR_LAST_IDX);
            case (r_idx)
                2'd0:    o_frame_byte = SYNC_FIRST;
                2'd1:    o_frame_byte = SYNC_SECOND;
                2'd2:    o_frame_byte = r_cmd.len_hi;
                default: o_frame_byte = r_cmd.data_byte;
            endcase
        end else begin
            o_byte_offset   = r_cmd.offset;
            o_last_of_frame = r_cmd.last;
            o_frame_byte    = r_cmd.data_byte;
        end
    end

endmodule

@@ rtl/core/sync_length_frame_deframer_unit.sv @@
// Top level of the sync/length frame deframer.
//
// Slave stream (i_s_*): one received serial byte per word. Master stream
// (o_m_*): one frame byte per word with its offset and the frame length;
// tlast marks the final byte of a frame. Frames start with 0xAA 0x55 and a
// 16-bit big-endian total length; lengths below 4 or at or above the limit
// are dropped and the hunt for 0xAA resumes.
// Config channel (i_cfg_*): writes the 16-bit frame length limit; it is
// always ready and must be written only while the block is idle.
// Path: an accepted payload byte is written into the command queue, then
// popped into the output register. The fourth header byte yields four words.
// Throughput: one byte per cycle on both sides for payload while the receiver
// is ready; the single output stage sends a header as four words. A four-entry
// command queue lets the parser run ahead while the output side works.
// Reset: synchronous, active low; the parser hunts for 0xAA, the queue is
// empty and the limit returns to 256.
// Receiver stall: the output word holds, the queue fills, and o_s_tready
// drops once the queue is full.
`timescale 1ns / 1ps
module sync_length_frame_deframer_unit
    import sldf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] frame_byte, [23:8] byte_offset,
                                     // [39:24] frame_length
    output logic        o_m_tlast    // last_of_frame
);

    logic        w_accept;
    logic        w_push;
    t_cmd        w_push_cmd;
    logic        w_pop;
    t_cmd        w_head_cmd;
    logic        w_full;
    logic        w_empty;
    logic [7:0]  w_frame_byte;
    logic [15:0] w_byte_offset;
    logic [15:0] w_frame_length;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_full;
    assign w_accept    = i_s_tvalid && !w_full;
    assign o_m_tdata   = {w_frame_length, w_byte_offset, w_frame_byte};

    sldf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (w_accept),
        .i_byte       (i_s_tdata),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    sldf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sldf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_head_cmd),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_frame_byte    (w_frame_byte),
        .o_byte_offset   (w_byte_offset),
        .o_frame_length  (w_frame_length),
        .o_last_of_frame (o_m_tlast)
    );

endmodule

@@ sim/sync_length_frame_deframer_unit_test.sv @@
// Self-checking testbench for the sync/length frame deframer top level.
`timescale 1ns / 1ps
module sync_length_frame_deframer_unit_test;
    import sldf_pkg::*;

    // One word on the master side
    typedef struct packed {
        logic [7:0]  fbyte;
        logic [15:0] offset;
        logic [15:0] flen;
        logic        last;
    } t_frame_word;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_WORD,
        CHK_HEADER
    } t_row_check;

    typedef struct packed {
        logic [7:0]  rx;
        t_row_check  chk;
        t_frame_word w;     // for a header row: the fourth header word
    } t_row;

    localparam t_frame_word NO_WORD    = '0;
    localparam int          IDLE_LIMIT = 3000;
    localparam int          N_DIRECTED = 27;
    localparam int          N_PHASES   = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;

    // Deframer state as predicted
    t_phase      rx_phase = PH_HUNT_AA;
    logic [7:0]  rx_len_hi = '0;
    logic [15:0] rx_frame_len = '0;
    logic [15:0] rx_offset = '0;
    logic [15:0] cfg_limit = LIMIT_RESET;

    t_frame_word words_due [$];
    int          fail_count = 0;
    int          rx_items = 0;
    int          idle_cycles = 0;
    int          s_calm = 0;
    int          m_calm = 0;
    int          m_stall = 0;

    // Directed bytes, limit at its reset value
    t_row dir_rows [N_DIRECTED] = '{
        '{8'h00,       CHK_NONE,    NO_WORD},   // ignored while hunting
        '{SYNC_FIRST,  CHK_NONE,    NO_WORD},
        '{SYNC_FIRST,  CHK_NONE,    NO_WORD},   // repeated sync byte
        '{SYNC_SECOND, CHK_NONE,    NO_WORD},
        '{8'h00,       CHK_NONE,    NO_WORD},
        '{8'h04,       CHK_HEADER,  '{8'h04, 16'd3, 16'd4, 1'b1}},  // header only
        '{SYNC_FIRST,  CHK_NONE,    NO_WORD},
        '{SYNC_SECOND, CHK_NONE,    NO_WORD},
        '{8'h00,       CHK_NONE,    NO_WORD},
        '{8'h06,       CHK_HEADER,  '{8'h06, 16'd3, 16'd6, 1'b0}},
        '{8'hFF,       CHK_WORD,    '{8'hFF, 16'd4, 16'd6, 1'b0}},
        '{8'h00,       CHK_WORD,    '{8'h00, 16'd5, 16'd6, 1'b1}},
        '{SYNC_FIRST,  CHK_NONE,    NO_WORD},   // undersized length
        '{SYNC_SECOND, CHK_NONE,    NO_WORD},
        '{8'h00,       CHK_NONE,    NO_WORD},
        '{8'h03,       CHK_NONE,    NO_WORD},
        '{SYNC_FIRST,  CHK_NONE,    NO_WORD},   // length equal to the limit
        '{SYNC_SECOND, CHK_NONE,    NO_WORD},
        '{8'h01,       CHK_NONE,    NO_WORD},
        '{8'h00,       CHK_NONE,    NO_WORD},
        '{SYNC_FIRST,  CHK_NONE,    NO_WORD},   // broken sync pair
        '{8'h12,       CHK_NONE,    NO_WORD},
        '{SYNC_FIRST,  CHK_PREDICT, NO_WORD},
        '{SYNC_SECOND, CHK_PREDICT, NO_WORD},
        '{8'h00,       CHK_PREDICT, NO_WORD},
        '{8'h05,       CHK_PREDICT, NO_WORD},
        '{8'h7E,       CHK_PREDICT, NO_WORD}
    };

    sync_length_frame_deframer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the predicted deframer by one byte; return the words it emits
    function automatic int deframe_byte(input logic [7:0] b, output t_frame_word words [4]);
        int          n = 0;
        logic [15:0] flen;
        logic        last;
        words = '{default: NO_WORD};
        flen = {rx_len_hi, b};
        case (rx_phase)
            PH_HUNT_55: begin
                if (b == SYNC_SECOND) rx_phase = PH_LEN_HI;
                else if (b != SYNC_FIRST) rx_phase = PH_HUNT_AA;
            end
            PH_LEN_HI: begin
                rx_len_hi = b;
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (flen >= cfg_limit || flen < HEADER_BYTES) begin
                    rx_phase = PH_HUNT_AA;
                end else begin
                    rx_frame_len = flen;
                    last = (flen == HEADER_BYTES);
                    words[0] = '{SYNC_FIRST, 16'd0, flen, 1'b0};
                    words[1] = '{SYNC_SECOND, 16'd1, flen, 1'b0};
                    words[2] = '{rx_len_hi, 16'd2, flen, 1'b0};
                    words[3] = '{b, 16'd3, flen, last};
                    n = 4;
                    if (last) begin
                        rx_phase = PH_HUNT_AA;
                    end else begin
                        rx_offset = HEADER_BYTES;
                        rx_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                last = ({1'b0, rx_offset} + 17'd1) >= {1'b0, rx_frame_len};
                words[0] = '{b, rx_offset, rx_frame_len, last};
                n = 1;
                if (last) rx_phase = PH_HUNT_AA;
                else rx_offset = rx_offset + 16'd1;
            end
            default: rx_phase = (b == SYNC_FIRST) ? PH_HUNT_55 : PH_HUNT_AA;
        endcase
        return n;
    endfunction

    // Idle length: mostly none, some short, a few long, with calm stretches
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == SYNC_SECOND);
        return b;
    endfunction

    // Hand one byte to the slave side and wait for it to be taken
    task automatic send_rx(input logic [7:0] b);
        repeat (pick_idle(s_calm)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        do @(posedge i_clk); while (!o_s_tready);
        rx_items++;
    endtask

    task automatic push_rx(input logic [7:0] b);
        t_frame_word words [4];
        int          n;
        send_rx(b);
        n = deframe_byte(b, words);
        for (int k = 0; k < n; k++) words_due.push_back(words[k]);
    endtask

    // Send sync pair and length; follow with payload while a frame is open
    task automatic send_frame(input logic [15:0] flen, input bit extra_sync);
        push_rx(SYNC_FIRST);
        if (extra_sync) push_rx(SYNC_FIRST);
        push_rx(SYNC_SECOND);
        push_rx(flen[15:8]);
        push_rx(flen[7:0]);
        while (rx_phase == PH_PAYLOAD) push_rx(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_run();
        int unsigned sel;
        logic [15:0] top;
        logic [15:0] flen;
        sel = $urandom_range(0, 99);
        top = (cfg_limit > 16'd24) ? 16'd24 : cfg_limit - 16'd1;
        if (sel < 60) begin
            if (cfg_limit <= HEADER_BYTES) flen = 16'($urandom_range(0, 20));
            else if (sel < 8 && cfg_limit <= 16'd48) flen = cfg_limit - 16'd1;
            else flen = 16'($urandom_range(HEADER_BYTES, top));
            send_frame(flen, $urandom_range(0, 4) == 0);
        end else if (sel < 70) begin
            flen = (sel < 63) ? cfg_limit : 16'($urandom_range(cfg_limit, 65535));
            send_frame(flen, 1'b0);
        end else if (sel < 78) begin
            send_frame(16'($urandom_range(0, 3)), 1'b0);
        end else if (sel < 88) begin
            // sync byte(s) followed by something other than the second sync byte
            push_rx(SYNC_FIRST);
            repeat ($urandom_range(0, 2)) push_rx(SYNC_FIRST);
            push_rx(noise_byte());
        end else begin
            repeat ($urandom_range(1, 4)) push_rx(noise_byte());
        end
    endtask

    // Write the length limit once every expected word has drained
    task automatic write_limit(input logic [15:0] value);
        i_s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_limit = value;
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= 200) $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Stimulus
    initial begin
        t_frame_word words [4];
        t_frame_word w;
        logic [15:0] limits [N_PHASES];
        int          targets [N_PHASES];
        int          n;
        int          start;

        limits = '{16'hFFFF, 16'd5, 16'd4, 16'($urandom_range(6, 40)),
                   16'($urandom_range(41, 65534))};
        targets = '{20, 15, 10, 20, 20};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_rows[r]) begin
            send_rx(dir_rows[r].rx);
            n = deframe_byte(dir_rows[r].rx, words);
            w = dir_rows[r].w;
            case (dir_rows[r].chk)
                CHK_PREDICT: for (int k = 0; k < n; k++) words_due.push_back(words[k]);
                CHK_WORD:    words_due.push_back(w);
                CHK_HEADER: begin
                    words_due.push_back('{SYNC_FIRST, 16'd0, w.flen, 1'b0});
                    words_due.push_back('{SYNC_SECOND, 16'd1, w.flen, 1'b0});
                    words_due.push_back('{w.flen[15:8], 16'd2, w.flen, 1'b0});
                    words_due.push_back(w);
                end
                default: ;
            endcase
        end

        // Random phases, one limit each
        for (int p = 0; p < N_PHASES; p++) begin
            write_limit(limits[p]);
            if (p == 0) begin
                send_frame(16'hFFFF, 1'b0);   // largest length, always dropped
            end
            start = rx_items;
            while (rx_items - start < targets[p]) send_random_run();
        end

        // Drain, then let the pipeline settle
        i_s_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sync_length_frame_deframer_unit test passed");
        end else begin
            $display("sync_length_frame_deframer_unit test failed");
        end
        $finish;
    end

    // Receiver ready with random stalls
    always @(posedge i_clk) begin
        if (m_stall == 0) m_stall = pick_idle(m_calm);
        if (m_stall > 0) begin
            m_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_word got;
        t_frame_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[7:0], o_m_tdata[23:8], o_m_tdata[39:24], o_m_tlast};
            if (words_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 200)
                    $error("unexpected word: byte %0d offset %0d length %0d last %0d",
                           got.fbyte, got.offset, got.flen, got.last);
            end else begin
                want = words_due.pop_front();
                check_field("frame_byte", want.fbyte, got.fbyte);
                check_field("byte_offset", want.offset, got.offset);
                check_field("frame_length", want.flen, got.flen);
                check_field("last_of_frame", want.last, got.last);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no word moved for %0d cycles, %0d words still due",
                   IDLE_LIMIT, words_due.size());
            $display("sync_length_frame_deframer_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
rtl/core/sldf_pkg.sv
rtl/core/sldf_front.sv
rtl/core/sldf_queue.sv
rtl/core/sldf_back.sv
rtl/core/sync_length_frame_deframer_unit.sv
sim/sync_length_frame_deframer_unit_test.sv
